// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_ON_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/frpc_pkg.sv =====
`default_nettype none

package frpc_pkg;

    localparam int PATH_LIMIT_DEF = 4095;

    localparam int TDATA_IN_W  = 48;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MAXPATH_W   = 12;

    typedef logic [2:0] status_t;
    localparam status_t ST_ACCEPT      = 3'd0;
    localparam status_t ST_DENIED      = 3'd1;
    localparam status_t ST_APPROVAL    = 3'd2;
    localparam status_t ST_UNSUPPORTED = 3'd3;
    localparam status_t ST_INVALID     = 3'd4;
    localparam status_t ST_TRAVERSAL   = 3'd5;
    localparam status_t ST_BUDGET      = 3'd6;

    typedef logic [1:0] op_t;
    localparam op_t OP_HEADER = 2'd0;
    localparam op_t OP_BYTE   = 2'd1;
    localparam op_t OP_END    = 2'd2;

    typedef logic [2:0] opn_t;
    localparam opn_t OPN_READ   = 3'd0;
    localparam opn_t OPN_WRITE  = 3'd1;
    localparam opn_t OPN_DELETE = 3'd2;
    localparam opn_t OPN_LIST   = 3'd3;
    localparam opn_t OPN_RENAME = 3'd4;
    localparam opn_t OPN_MKDIR  = 3'd5;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ALLOW_READ   = 3'd0;
    localparam cfg_idx_t CFG_ALLOW_WRITE  = 3'd1;
    localparam cfg_idx_t CFG_ALLOW_MANAGE = 3'd2;
    localparam cfg_idx_t CFG_MAX_PATH     = 3'd3;
    localparam cfg_idx_t CFG_MAX_TRANSFER = 3'd4;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Control from the request sequencer to the path tracker.
    typedef struct packed {
        logic take;
        logic clear;
    } path_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/file_request_path_checker.sv =====
`default_nettype none

// File request path checker.
// Input items arrive on the s_axis channel: tuser carries the item kind
// (header, path byte, end of path) and tdata the header fields or one path
// byte. A request is a header, the primary path bytes and an end mark; a
// rename adds a secondary path with its own end mark. One status item leaves
// on m_axis at the end mark that closes the request; other items give none.
// Policy registers are written via cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, as the block does not enforce it. Each input item
// is held in an input register until it can advance, then updates flags in
// the path tracker and request logic; the output register holds the status.
// One item is taken per cycle; the status output register decouples the
// two sides. If the receiver stalls with a status item held, the block keeps
// taking items until the next status-producing item waits in the input
// register, then drops s_axis_tready.
// Reset (aresetn low, synchronous) empties both registers, clears request
// state and sets the policy registers to their defaults.
module file_request_path_checker #(
    parameter int PATH_LIMIT = frpc_pkg::PATH_LIMIT_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] operation, [3] approved, [4] trusted_component,
    // [36:5] transfer length, [44:37] path_char, [47:45] zero
    input  wire [frpc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // [1:0] op
    input  wire [frpc_pkg::TUSER_IN_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [2:0] status, [7:3] zero
    output logic [frpc_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    input  wire                                cfg_we,
    input  wire [frpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [frpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import frpc_pkg::*;

    // Policy registers.
    logic                  allow_read_reg, allow_write_reg, allow_manage_reg;
    logic [MAXPATH_W-1:0]  max_path_reg;
    logic [31:0]           max_xfer_reg;

    // Input register.
    logic                  in_valid_reg;
    op_t                   in_op_reg;
    logic [44:0]           in_data_reg;

    // Request state.
    opn_t                  opn_held_reg, opn_held_next;
    logic                  appr_miss_reg, appr_miss_next;
    logic                  budget_reg, budget_next;
    logic                  second_reg, second_next;
    status_t               first_st_reg, first_st_next;

    // Output register.
    logic                  out_valid_reg;
    status_t               out_status_reg;

    path_ctrl_t            pctrl;
    status_t               path_st;
    status_t               final_st;
    status_t               st_a, st_b;
    logic                  produces;
    logic                  advance;

    opn_t                  in_opn;
    logic                  in_approved, in_trusted;
    logic [31:0]           in_bytes;
    logic [7:0]            in_char;

    assign in_opn      = in_data_reg[2:0];
    assign in_approved = in_data_reg[3];
    assign in_trusted  = in_data_reg[4];
    assign in_bytes    = in_data_reg[36:5];
    assign in_char     = in_data_reg[44:37];

    // The first end mark of a rename closes only the primary path.
    assign produces = (in_op_reg == OP_END) && (second_reg || opn_held_reg != OPN_RENAME);
    assign advance  = in_valid_reg && (!produces || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W-3){1'b0}}, out_status_reg};

    frpc_path_track #(
        .PATH_LIMIT(PATH_LIMIT)
    ) u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (pctrl),
        .path_char     (in_char),
        .len_limit     (max_path_reg),
        .path_result   (path_st)
    );

    always_comb begin
        st_a = second_reg ? first_st_reg : path_st;
        st_b = second_reg ? path_st : ST_ACCEPT;
        if (appr_miss_reg) begin
            final_st = ST_APPROVAL;
        end else if (st_a != ST_ACCEPT) begin
            final_st = st_a;
        end else if (st_b != ST_ACCEPT) begin
            final_st = st_b;
        end else if (budget_reg) begin
            final_st = ST_BUDGET;
        end else begin
            case (opn_held_reg)
                OPN_READ:  final_st = (allow_read_reg || allow_manage_reg) ? ST_ACCEPT
                                                                            : ST_DENIED;
                OPN_WRITE: final_st = (allow_write_reg || allow_manage_reg) ? ST_ACCEPT
                                                                             : ST_DENIED;
                OPN_DELETE, OPN_LIST, OPN_RENAME, OPN_MKDIR:
                    final_st = allow_manage_reg ? ST_ACCEPT : ST_DENIED;
                default:   final_st = ST_UNSUPPORTED;
            endcase
        end
    end

    always_comb begin
        opn_held_next  = opn_held_reg;
        appr_miss_next = appr_miss_reg;
        budget_next    = budget_reg;
        second_next    = second_reg;
        first_st_next  = first_st_reg;
        pctrl          = '{take: 1'b0, clear: 1'b0};
        if (advance) begin
            case (in_op_reg)
                OP_HEADER: begin
                    opn_held_next  = in_opn;
                    appr_miss_next = !(in_approved || in_trusted);
                    budget_next    = in_bytes > max_xfer_reg;
                    second_next    = 1'b0;
                    first_st_next  = ST_ACCEPT;
                    pctrl.clear    = 1'b1;
                end
                OP_BYTE: begin
                    pctrl.take = 1'b1;
                end
                OP_END: begin
                    pctrl.clear = 1'b1;
                    if (!produces) begin
                        first_st_next = path_st;
                        second_next   = 1'b1;
                    end else begin
                        first_st_next = ST_ACCEPT;
                        second_next   = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_read_reg   <= 1'b0;
            allow_write_reg  <= 1'b0;
            allow_manage_reg <= 1'b0;
            max_path_reg     <= '1;
            max_xfer_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ALLOW_READ:   allow_read_reg   <= cfg_data[0];
                CFG_ALLOW_WRITE:  allow_write_reg  <= cfg_data[0];
                CFG_ALLOW_MANAGE: allow_manage_reg <= cfg_data[0];
                CFG_MAX_PATH:     max_path_reg     <= cfg_data[MAXPATH_W-1:0];
                CFG_MAX_TRANSFER: max_xfer_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            opn_held_reg  <= OPN_READ;
            appr_miss_reg <= 1'b0;
            budget_reg    <= 1'b0;
            second_reg    <= 1'b0;
            first_st_reg  <= ST_ACCEPT;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            opn_held_reg  <= opn_held_next;
            appr_miss_reg <= appr_miss_next;
            budget_reg    <= budget_next;
            second_reg    <= second_next;
            first_st_reg  <= first_st_next;
            if (advance && produces) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg   <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[44:0];
        end
        if (advance && produces) begin
            out_status_reg <= final_st;
        end
    end

    // The secondary path phase exists only for rename requests.
    `ASSERT_ON_CLK(a_second_is_rename, aclk, aresetn, second_reg |-> (opn_held_reg == OPN_RENAME))
    // A stored primary result is kept only while the secondary path is open.
    `ASSERT_ON_CLK(a_first_st_phase, aclk, aresetn, (first_st_reg != ST_ACCEPT) |-> second_reg)
    // The input side stalls only on a held item that cannot move on.
    `ASSERT_ON_CLK(a_stall_cause, aclk, aresetn,
        !s_axis_tready |-> (in_valid_reg && produces && out_valid_reg && !m_axis_tready))
    // Every delivered status is one of the defined codes.
    `ASSERT_ON_CLK(a_status_range, aclk, aresetn,
        m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7))

endmodule

`default_nettype wire

// ===== rtl/frpc_path_track.sv =====
`default_nettype none

`include "assert_macros.svh"

module frpc_path_track #(
    parameter int PATH_LIMIT = frpc_pkg::PATH_LIMIT_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  frpc_pkg::path_ctrl_t               ctrl,
    input  wire [7:0]                          path_char,
    input  wire [frpc_pkg::MAXPATH_W-1:0]      len_limit,
    output frpc_pkg::status_t                  path_result
);
    import frpc_pkg::*;

    // Length saturates at PATH_LIMIT + 1.
    localparam int LEN_W = $clog2(PATH_LIMIT + 2);
    localparam int CMP_W = (LEN_W > MAXPATH_W) ? LEN_W : MAXPATH_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATH_LIMIT);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             sws_reg, sws_next;
    logic             prev_slash_reg, prev_slash_next;
    logic             bad_reg, bad_next;
    logic [1:0]       seg_len_reg, seg_len_next;
    logic             all_dots_reg, all_dots_next;
    logic             trav_reg, trav_next;

    logic slash;
    logic seg_dots;
    logic too_long;

    assign slash    = (path_char == CH_SLASH);
    assign seg_dots = all_dots_reg && (seg_len_reg == 2'd1 || seg_len_reg == 2'd2);
    assign too_long = (CMP_W'(len_reg) > CMP_W'(len_limit)) || (len_reg > LEN_MAX);

    always_comb begin
        len_next        = len_reg;
        sws_next        = sws_reg;
        prev_slash_next = prev_slash_reg;
        bad_next        = bad_reg;
        seg_len_next    = seg_len_reg;
        all_dots_next   = all_dots_reg;
        trav_next       = trav_reg;
        if (ctrl.clear) begin
            len_next        = '0;
            sws_next        = 1'b0;
            prev_slash_next = 1'b0;
            bad_next        = 1'b0;
            seg_len_next    = 2'd0;
            all_dots_next   = 1'b1;
            trav_next       = 1'b0;
        end else if (ctrl.take) begin
            if (path_char < CH_SPACE || path_char == CH_BACKSLASH ||
                (slash && prev_slash_reg && len_reg != '0)) begin
                bad_next = 1'b1;
            end
            if (len_reg == '0) begin
                sws_next = slash;
            end else if (slash) begin
                // A finished segment of one or two dots is a traversal.
                if (seg_dots) begin
                    trav_next = 1'b1;
                end
                seg_len_next  = 2'd0;
                all_dots_next = 1'b1;
            end else begin
                if (seg_len_reg != 2'd3) begin
                    seg_len_next = seg_len_reg + 2'd1;
                end
                if (path_char != CH_DOT) begin
                    all_dots_next = 1'b0;
                end
            end
            prev_slash_next = slash;
            if (len_reg <= LEN_MAX) begin
                len_next = len_reg + 1'b1;
            end
        end
    end

    always_comb begin
        if (len_reg == '0 || too_long || !sws_reg ||
            (len_reg > LEN_W'(1) && prev_slash_reg) || bad_reg) begin
            path_result = ST_INVALID;
        end else if (trav_reg || seg_dots) begin
            path_result = ST_TRAVERSAL;
        end else begin
            path_result = ST_ACCEPT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= '0;
            sws_reg        <= 1'b0;
            prev_slash_reg <= 1'b0;
            bad_reg        <= 1'b0;
            seg_len_reg    <= 2'd0;
            all_dots_reg   <= 1'b1;
            trav_reg       <= 1'b0;
        end else begin
            len_reg        <= len_next;
            sws_reg        <= sws_next;
            prev_slash_reg <= prev_slash_next;
            bad_reg        <= bad_next;
            seg_len_reg    <= seg_len_next;
            all_dots_reg   <= all_dots_next;
            trav_reg       <= trav_next;
        end
    end

    // Segment bytes are only counted once the leading byte has been taken.
    `ASSERT_ON_CLK(a_seg_needs_len, aclk, aresetn, (seg_len_reg != 2'd0) |-> (len_reg != '0))
    // The length never passes its saturation point.
    `ASSERT_ON_CLK(a_len_sat, aclk, aresetn, len_reg <= LEN_W'(PATH_LIMIT + 1))

endmodule

`default_nettype wire
